/* src/pjs_pkg.sv */
// Package for the periodic job slot scheduler.
// Holds the field widths, codes, controller states and control structs.
// No dependencies.
package pjs_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int KIND_W      = 1;
    localparam int JOB_W       = 16;
    localparam int TIME_W      = 32;
    localparam int ELAPSED_W   = 16;
    localparam int SLOT_W      = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W     = JOB_W + TIME_W + TIME_W;

    localparam logic [KIND_W-1:0] KIND_REG  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REG,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic rd_en;
        logic step;
        logic reg_commit;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic fill_zero;
        logic scan_end;
        logic fire;
        logic can_report;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

/* src/pjs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module pjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/pjs_ctrl.sv */
// Controller state machine for the periodic job slot scheduler.
// Depends on pjs_pkg; drives commands to pjs_dp from its status.
module pjs_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [pjs_pkg::KIND_W-1:0]  i_kind,
    input  pjs_pkg::t_status            i_status,
    output logic                        o_in_ready,
    output pjs_pkg::t_cmd               o_cmd
);

    pjs_pkg::t_state r_state;
    pjs_pkg::t_state n_state;
    logic            stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pjs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        stall      = i_status.fire && i_status.can_report && i_status.pend_valid
                     && !i_status.out_free;
        unique case (r_state)
            pjs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == pjs_pkg::KIND_REG) begin
                        n_state = pjs_pkg::S_REG;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.rd_en      = 1'b1;
                        n_state = i_status.fill_zero ? pjs_pkg::S_IDLE : pjs_pkg::S_SCAN;
                    end
                end
            end
            pjs_pkg::S_REG: begin
                if (i_status.out_free) begin
                    o_cmd.reg_commit = 1'b1;
                    n_state = pjs_pkg::S_IDLE;
                end
            end
            pjs_pkg::S_SCAN: begin
                if (!stall) begin
                    o_cmd.step = 1'b1;
                    if (i_status.scan_end) begin
                        n_state = pjs_pkg::S_FLUSH;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
            end
            pjs_pkg::S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = pjs_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = pjs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pjs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* src/pjs_dp.sv */
// Datapath for the periodic job slot scheduler: clock, fill count, slot RAM,
// scan index, pending fire and output register. Depends on pjs_pkg, pjs_ram.
module pjs_dp #(
    parameter int SLOTS = pjs_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pjs_pkg::t_cmd                  i_cmd,
    input  logic [pjs_pkg::KIND_W-1:0]     i_kind,
    input  logic [pjs_pkg::JOB_W-1:0]      i_job_id,
    input  logic [pjs_pkg::TIME_W-1:0]     i_period,
    input  logic [pjs_pkg::ELAPSED_W-1:0]  i_elapsed,
    input  logic                           i_out_ready,
    output pjs_pkg::t_status               o_status,
    output logic                           o_out_valid,
    output logic [pjs_pkg::KIND_W-1:0]     o_reply_kind,
    output logic                           o_accepted,
    output logic [pjs_pkg::SLOT_W-1:0]     o_slot,
    output logic [pjs_pkg::JOB_W-1:0]      o_fired_job,
    output logic                           o_last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int JW = pjs_pkg::JOB_W;
    localparam int TW = pjs_pkg::TIME_W;

    logic [TW-1:0]                r_clock;
    logic [CW-1:0]                r_fill;
    logic [JW-1:0]                r_job;
    logic [TW-1:0]                r_period;
    logic [AW-1:0]                r_idx;
    logic [pjs_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_pend_valid;
    logic [AW-1:0]                r_pend_slot;
    logic [JW-1:0]                r_pend_job;

    logic                         r_out_valid;
    logic [pjs_pkg::KIND_W-1:0]   r_out_kind;
    logic                         r_out_acc;
    logic [pjs_pkg::SLOT_W-1:0]   r_out_slot;
    logic [JW-1:0]                r_out_job;
    logic                         r_out_last;

    logic                         out_free;
    logic                         reg_ok;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [pjs_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [pjs_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [JW-1:0]                rd_job;
    logic [TW-1:0]                rd_period;
    logic [TW-1:0]                rd_due;
    logic                         fire;
    logic                         can_report;
    logic                         report;

    assign out_free   = !r_out_valid || i_out_ready;
    assign reg_ok     = (r_job != '0) && (r_period != '0) && (r_fill < CW'(SLOTS));
    assign {rd_job, rd_period, rd_due} = ram_rdata;
    assign fire       = (r_clock >= rd_due);
    assign can_report = (r_cnt < pjs_pkg::CNT_W'(pjs_pkg::MAX_RESULTS));
    assign report     = i_cmd.step && fire && can_report;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {rd_job, rd_period, rd_due + rd_period};
        if (i_cmd.reg_commit) begin
            ram_we    = reg_ok;
            ram_waddr = r_fill[AW-1:0];
            ram_wdata = {r_job, r_period, r_clock + r_period};
        end else if (i_cmd.step) begin
            ram_we = fire;
        end
    end

    assign ram_raddr = i_cmd.scan_start ? '0 : r_idx + AW'(1);

    pjs_ram #(
        .WIDTH (pjs_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock      <= '0;
            r_fill       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cmd.accept && i_kind == pjs_pkg::KIND_TICK) begin
                r_clock <= r_clock + TW'(i_elapsed);
            end
            if (i_cmd.scan_start) begin
                r_idx        <= '0;
                r_cnt        <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.reg_commit && reg_ok) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + AW'(1);
            end
            if (report) begin
                r_cnt        <= r_cnt + pjs_pkg::CNT_W'(1);
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.reg_commit || i_cmd.flush || (report && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_job    <= i_job_id;
            r_period <= i_period;
        end
        if (report) begin
            r_pend_slot <= r_idx;
            r_pend_job  <= rd_job;
        end
        if (i_cmd.reg_commit) begin
            r_out_kind <= pjs_pkg::KIND_REG;
            r_out_acc  <= reg_ok;
            r_out_slot <= reg_ok ? pjs_pkg::SLOT_W'(r_fill) : '0;
            r_out_job  <= reg_ok ? r_job : '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.flush || (report && r_pend_valid)) begin
            r_out_kind <= pjs_pkg::KIND_TICK;
            r_out_acc  <= 1'b1;
            r_out_slot <= pjs_pkg::SLOT_W'(r_pend_slot);
            r_out_job  <= r_pend_job;
            r_out_last <= i_cmd.flush;
        end
    end

    always_comb begin
        o_status.fill_zero  = (r_fill == '0);
        o_status.scan_end   = (CW'(r_idx) == r_fill - CW'(1));
        o_status.fire       = fire;
        o_status.can_report = can_report;
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_reply_kind = r_out_kind;
    assign o_accepted   = r_out_acc;
    assign o_slot       = r_out_slot;
    assign o_fired_job  = r_out_job;
    assign o_last       = r_out_last;

endmodule

/* src/periodic_job_slot_scheduler.sv */
// Periodic job slot scheduler, top level: controller plus datapath.
// Depends on pjs_pkg, pjs_ctrl, pjs_dp (which holds pjs_ram).
// One item is in work at a time. A register item passes S_REG, which waits
// for a free output register, and gives one reply. A tick item updates the
// clock and starts the slot RAM read, then scans the registered slots (the
// single RAM read port scans one slot a cycle while the scan is not stalled),
// then hands out the last pending fire event, if any; results wait in an
// output register, and a stalled output holds the scan. Slots fill lowest
// first and are never freed, so no clearing pass runs after reset.
module periodic_job_slot_scheduler #(
    parameter int SLOTS = pjs_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pjs_pkg::KIND_W-1:0]     i_kind,
    input  logic [pjs_pkg::JOB_W-1:0]      i_job_id,
    input  logic [pjs_pkg::TIME_W-1:0]     i_period,
    input  logic [pjs_pkg::ELAPSED_W-1:0]  i_elapsed,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pjs_pkg::KIND_W-1:0]     o_reply_kind,
    output logic                           o_accepted,
    output logic [pjs_pkg::SLOT_W-1:0]     o_slot,
    output logic [pjs_pkg::JOB_W-1:0]      o_fired_job,
    output logic                           o_last
);

    pjs_pkg::t_cmd    cmd;
    pjs_pkg::t_status status;

    pjs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pjs_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_kind       (i_kind),
        .i_job_id     (i_job_id),
        .i_period     (i_period),
        .i_elapsed    (i_elapsed),
        .i_out_ready  (i_out_ready),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_reply_kind (o_reply_kind),
        .o_accepted   (o_accepted),
        .o_slot       (o_slot),
        .o_fired_job  (o_fired_job),
        .o_last       (o_last)
    );

endmodule
